[design/peak_trough_amplitude_finder_defines.svh]
// ----------------------------------------------------------------------------
// Peak trough amplitude finder assertion macros
// Shared property shorthands for the checker of the swing finder.
// ----------------------------------------------------------------------------
`ifndef PEAK_TROUGH_AMPLITUDE_FINDER_DEFINES_SVH
`define PEAK_TROUGH_AMPLITUDE_FINDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PTAF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PTAF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ptaf_pkg.sv]
// ----------------------------------------------------------------------------
// Peak trough amplitude finder package
// Widths, slope codes and the item and result records shared by the modules.
// ----------------------------------------------------------------------------
package ptaf_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAX_SAMPLES = 65536;
  // count saturates at MAX_SAMPLES, so it must hold that value itself
  localparam int CNT_BITS    = $clog2(MAX_SAMPLES + 1);
  localparam int SWING_BITS  = 24;
  localparam int PERIOD_BITS = 17;
  localparam int POS_BITS    = 16;

  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int RES_BITS      = SWING_BITS + PERIOD_BITS + POS_BITS;
  localparam int OUT_DATA_BITS = ((RES_BITS + 7) / 8) * 8;
  localparam int OUT_USER_BITS = 2;

  typedef enum logic [1:0] {
    SLOPE_FLAT = 2'd0,
    SLOPE_UP   = 2'd1,
    SLOPE_DOWN = 2'd2
  } slope_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } item_t;

  typedef struct packed {
    logic [SWING_BITS-1:0]  swing;
    logic [PERIOD_BITS-1:0] period_samples;
    logic [POS_BITS-1:0]    peak_position;
    logic                   found;
    logic                   overflow;
  } result_t;

endpackage

[design/peak_trough_amplitude_finder.sv]
// ----------------------------------------------------------------------------
// Peak trough amplitude finder
// Largest peak to trough swing of a window of signed samples, with its
// period and the position of its first turning point.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload                                   | framing
//  --------+-----------+-------------------------------------------+---------
//  in_*    | slave     | tdata: sample[23:0]                       | tlast
//  out_*   | master    | tdata: swing, period_samples, peak_pos    | one/window
//          |           | tuser: found, overflow                    |
//
// Rate: one sample per clock while in_tready is high; the tlast sample passes
//   the input register, then the result register, before out_tvalid rises.
// The rate is set by the input register feeding one compare, subtract and
//   max update into the window state, all combinational.
// Reset: rst_n synchronous, active low; clears the window state and both
//   valid flags.
// Stalls: in_tready drops only while a tlast sample waits in the input
//   register and the result register still holds an untaken result.
//
module peak_trough_amplitude_finder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tdata: [23:0] sample
  input  logic [ptaf_pkg::IN_DATA_BITS-1:0]    in_tdata,
  input  logic                                 in_tlast,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata: [23:0] swing, [40:24] period_samples, [56:41] peak_position,
  //        [63:57] zero
  output logic [ptaf_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  // tuser: [0] found, [1] overflow
  output logic [ptaf_pkg::OUT_USER_BITS-1:0]   out_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready
);

  ptaf_pkg::item_t   in_item;
  ptaf_pkg::item_t   s1_item;
  logic              s1_valid;
  logic              advance;
  logic              out_free;
  ptaf_pkg::result_t track_result;
  ptaf_pkg::result_t out_result;

  assign in_item.sample = in_tdata[ptaf_pkg::SAMPLE_BITS-1:0];
  assign in_item.last   = in_tlast;

  // consume the held sample unless it closes a window and the result slot is busy
  assign advance = s1_valid && (!s1_item.last || out_free);

  ptaf_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  ptaf_track u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (s1_item),
    .result (track_result)
  );

  ptaf_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && s1_item.last),
    .result     (track_result),
    .free       (out_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  // pack the result fields from the lowest bit up, zero the padding
  assign out_tdata = ptaf_pkg::OUT_DATA_BITS'({out_result.peak_position,
                                               out_result.period_samples,
                                               out_result.swing});
  assign out_tuser = {out_result.overflow, out_result.found};

endmodule

[design/ptaf_in_reg.sv]
// ----------------------------------------------------------------------------
// Peak trough amplitude finder input register
// Holds one accepted sample until the tracker consumes it.
// ----------------------------------------------------------------------------
module ptaf_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ptaf_pkg::item_t in_item,
  input  logic            advance,
  output logic            s1_valid,
  output ptaf_pkg::item_t s1_item
);

  logic            valid_r;
  logic            valid_nxt;
  ptaf_pkg::item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

[design/ptaf_track.sv]
// ----------------------------------------------------------------------------
// Peak trough amplitude finder tracker
// Follows slope, turning points and the best swing of the current window.
// ----------------------------------------------------------------------------
module ptaf_track (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  ptaf_pkg::item_t   item,
  output ptaf_pkg::result_t result
);

  localparam int SB = ptaf_pkg::SAMPLE_BITS;
  localparam int CB = ptaf_pkg::CNT_BITS;
  localparam int WB = ptaf_pkg::SWING_BITS;
  localparam int PB = ptaf_pkg::PERIOD_BITS;
  localparam int QB = ptaf_pkg::POS_BITS;

  logic [SB-1:0]    prev_r,       prev_nxt;
  ptaf_pkg::slope_t slope_r,      slope_nxt;
  logic [CB-1:0]    count_r,      count_nxt;
  logic             have_turn_r,  have_turn_nxt;
  logic [SB-1:0]    turn_value_r, turn_value_nxt;
  logic [QB-1:0]    turn_pos_r,   turn_pos_nxt;
  logic             best_found_r, best_found_nxt;
  logic [WB-1:0]    best_swing_r, best_swing_nxt;
  logic [PB-1:0]    best_period_r, best_period_nxt;
  logic [QB-1:0]    best_pos_r,   best_pos_nxt;
  logic             ovf_r,        ovf_nxt;

  ptaf_pkg::slope_t s2;
  logic             opposite;
  logic [QB-1:0]    here;
  logic [WB-1:0]    swing_cur;
  logic [QB-1:0]    gap;

  always_comb begin
    if ($signed(item.sample) > $signed(prev_r)) begin
      s2 = ptaf_pkg::SLOPE_UP;
    end else if ($signed(item.sample) < $signed(prev_r)) begin
      s2 = ptaf_pkg::SLOPE_DOWN;
    end else begin
      s2 = ptaf_pkg::SLOPE_FLAT;
    end
  end

  assign opposite = ((s2 == ptaf_pkg::SLOPE_UP) && (slope_r == ptaf_pkg::SLOPE_DOWN)) ||
                    ((s2 == ptaf_pkg::SLOPE_DOWN) && (slope_r == ptaf_pkg::SLOPE_UP));

  assign here = QB'(count_r - CB'(1));
  assign gap  = here - turn_pos_r;

  // full swing of two signed samples always fits the unsigned field
  always_comb begin
    if ($signed(prev_r) >= $signed(turn_value_r)) begin
      swing_cur = WB'({prev_r[SB-1], prev_r} - {turn_value_r[SB-1], turn_value_r});
    end else begin
      swing_cur = WB'({turn_value_r[SB-1], turn_value_r} - {prev_r[SB-1], prev_r});
    end
  end

  always_comb begin
    prev_nxt        = prev_r;
    slope_nxt       = slope_r;
    count_nxt       = count_r;
    have_turn_nxt   = have_turn_r;
    turn_value_nxt  = turn_value_r;
    turn_pos_nxt    = turn_pos_r;
    best_found_nxt  = best_found_r;
    best_swing_nxt  = best_swing_r;
    best_period_nxt = best_period_r;
    best_pos_nxt    = best_pos_r;
    ovf_nxt         = ovf_r;
    if (count_r >= CB'(ptaf_pkg::MAX_SAMPLES)) begin
      ovf_nxt = 1'b1;
    end else begin
      if (count_r == CB'(2)) begin
        slope_nxt = s2;
      end else if (count_r >= CB'(3)) begin
        if (opposite) begin
          if (have_turn_r && (!best_found_r || (swing_cur > best_swing_r))) begin
            best_swing_nxt  = swing_cur;
            best_period_nxt = PB'({1'b0, gap} << 1);
            best_pos_nxt    = turn_pos_r;
            best_found_nxt  = 1'b1;
          end
          turn_value_nxt = prev_r;
          turn_pos_nxt   = here;
          have_turn_nxt  = 1'b1;
          slope_nxt      = s2;
        end else if (slope_r == ptaf_pkg::SLOPE_FLAT) begin
          slope_nxt = s2;
        end
      end
      prev_nxt  = item.sample;
      count_nxt = count_r + CB'(1);
    end
  end

  // best fields stay zero until a pair is found, so they pass through as is
  always_comb begin
    result.swing          = best_swing_nxt;
    result.period_samples = best_period_nxt;
    result.peak_position  = best_pos_nxt;
    result.found          = best_found_nxt;
    result.overflow       = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last)) begin
      prev_r        <= '0;
      slope_r       <= ptaf_pkg::SLOPE_FLAT;
      count_r       <= '0;
      have_turn_r   <= 1'b0;
      turn_value_r  <= '0;
      turn_pos_r    <= '0;
      best_found_r  <= 1'b0;
      best_swing_r  <= '0;
      best_period_r <= '0;
      best_pos_r    <= '0;
      ovf_r         <= 1'b0;
    end else if (step) begin
      prev_r        <= prev_nxt;
      slope_r       <= slope_nxt;
      count_r       <= count_nxt;
      have_turn_r   <= have_turn_nxt;
      turn_value_r  <= turn_value_nxt;
      turn_pos_r    <= turn_pos_nxt;
      best_found_r  <= best_found_nxt;
      best_swing_r  <= best_swing_nxt;
      best_period_r <= best_period_nxt;
      best_pos_r    <= best_pos_nxt;
      ovf_r         <= ovf_nxt;
    end
  end

endmodule

[design/ptaf_out_reg.sv]
// ----------------------------------------------------------------------------
// Peak trough amplitude finder result register
// Holds one window result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ptaf_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ptaf_pkg::result_t result,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output ptaf_pkg::result_t out_result
);

  logic              valid_r;
  logic              valid_nxt;
  ptaf_pkg::result_t result_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

[design/ptaf_checker.sv]
// ----------------------------------------------------------------------------
// Peak trough amplitude finder checker
// Port-level properties of the swing finder, bound to the top level.
// ----------------------------------------------------------------------------
`include "peak_trough_amplitude_finder_defines.svh"

module ptaf_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic [ptaf_pkg::IN_DATA_BITS-1:0]  in_tdata,
  input logic                               in_tlast,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [ptaf_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input logic [ptaf_pkg::OUT_USER_BITS-1:0] out_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready
);

  logic in_fire;
  logic out_stall;

  assign in_fire   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;

  // a stalled result must hold
  `PTAF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // without a pair every data field reads zero
  `PTAF_ASSERT_NOW(a_none_zero, clk, rst_n, out_tvalid && !out_tuser[0],
    out_tdata == '0, "nonzero data on a window without a pair")

  // a found pair spans at least one sample, so the period is even and nonzero
  `PTAF_ASSERT_NOW(a_period_even, clk, rst_n, out_tvalid && out_tuser[0],
    !out_tdata[24] && (out_tdata[40:24] != '0), "bad period on a found pair")

  // the input side only stalls while a result is waiting
  `PTAF_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_tready,
    out_stall, "input stalled with a free result slot")

  // an accepted sample transaction carries known data
  `PTAF_ASSERT_NOW(a_in_known, clk, rst_n, in_fire, !$isunknown({in_tdata, in_tlast}),
    "unknown sample accepted")

endmodule

bind peak_trough_amplitude_finder ptaf_checker u_ptaf_checker (.*);
